// ===== rtl/ulcfp_pkg.sv =====
// Shared types, constants and reply byte table of the LED command frame parser.
`default_nettype none

package ulcfp_pkg;

    // Default configuration of the LED bank.
    localparam int DEFAULT_NUM_LEDS     = 4;
    localparam int DEFAULT_BITS_PER_LED = 3;

    // Header field layout.
    localparam int HEADER_LAST_POS = 3;
    localparam int LONG_FLAG_BIT   = 4;
    localparam int ON_FLAG_BIT     = 7;

    // Last word index of each reply frame.
    localparam logic [2:0] QUERY_LAST_IDX = 3'd5;
    localparam logic [2:0] OK_LAST_IDX    = 3'd6;

    // Reply frame bytes.
    localparam logic [7:0] QUERY_OPEN  = 8'hA1;
    localparam logic [7:0] QUERY_CLOSE = 8'h41;
    localparam logic [7:0] OK_OPEN     = 8'hA2;
    localparam logic [7:0] OK_CLOSE    = 8'h42;
    localparam logic [7:0] CHAR_O      = 8'h4F;
    localparam logic [7:0] CHAR_K      = 8'h4B;

    typedef enum logic [1:0] {
        PHASE_HEADER = 2'd0,
        PHASE_DATA   = 2'd1
    } phase_t;

    typedef enum logic {
        REPLY_QUERY = 1'b0,
        REPLY_OK    = 1'b1
    } reply_kind_t;

    // Request from the parser to start a reply frame.
    typedef struct packed {
        logic        start;
        reply_kind_t kind;
        logic [3:0]  switches;
    } reply_req_t;

    // Byte at position idx of a reply frame.
    function automatic logic [7:0] reply_byte(reply_kind_t kind, logic [2:0] idx,
                                              logic [3:0] switches);
        logic [7:0] b;
        b = 8'h00;
        case (kind)
            REPLY_QUERY:
            begin
                case (idx)
                    3'd0:    b = QUERY_OPEN;
                    3'd4:    b = {4'h0, switches};
                    3'd5:    b = QUERY_CLOSE;
                    default: b = 8'h00;
                endcase
            end
            REPLY_OK:
            begin
                case (idx)
                    3'd0:    b = OK_OPEN;
                    3'd4:    b = CHAR_O;
                    3'd5:    b = CHAR_K;
                    3'd6:    b = OK_CLOSE;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ulcfp_parser.sv =====
// Frame parser: header and data phases, LED pattern register, reply requests.
`default_nettype none

module ulcfp_parser
    import ulcfp_pkg::*;
#(
    parameter int NUM_LEDS     = DEFAULT_NUM_LEDS,
    parameter int BITS_PER_LED = DEFAULT_BITS_PER_LED
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic [3:0]                       switch_levels,
    output reply_req_t                            req,
    output logic      [NUM_LEDS*BITS_PER_LED-1:0] led_pattern
);

    localparam int LED_W  = NUM_LEDS * BITS_PER_LED;
    localparam int SLOT_W = $clog2(NUM_LEDS + 1);

    phase_t            phase_reg, phase_next;
    logic [4:0]        byte_position_reg, byte_position_next;
    logic [3:0]        length_nibble_reg, length_nibble_next;
    logic              is_long_frame_reg, is_long_frame_next;
    logic [7:0]        device_mask_reg, device_mask_next;
    logic [LED_W-1:0]  led_pattern_reg, led_pattern_next;
    logic [SLOT_W-1:0] next_led_slot_reg, next_led_slot_next;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PHASE_HEADER;
            byte_position_reg <= '0;
            length_nibble_reg <= '0;
            is_long_frame_reg <= 1'b0;
            device_mask_reg   <= '0;
            led_pattern_reg   <= '0;
            next_led_slot_reg <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_position_reg <= byte_position_next;
            length_nibble_reg <= length_nibble_next;
            is_long_frame_reg <= is_long_frame_next;
            device_mask_reg   <= device_mask_next;
            led_pattern_reg   <= led_pattern_next;
            next_led_slot_reg <= next_led_slot_next;
        end
    end

    // Next state for one accepted word.
    always_comb
    begin
        logic [1:0] pos;
        logic       found;
        phase_next         = phase_reg;
        byte_position_next = byte_position_reg;
        length_nibble_next = length_nibble_reg;
        is_long_frame_next = is_long_frame_reg;
        device_mask_next   = device_mask_reg;
        led_pattern_next   = led_pattern_reg;
        next_led_slot_next = next_led_slot_reg;
        req.start          = 1'b0;
        req.kind           = REPLY_OK;
        req.switches       = switch_levels;
        pos                = byte_position_reg[1:0];
        found              = 1'b0;

        if (accept)
        begin
            if (phase_reg != PHASE_DATA)
            begin
                // Header phase: collect count, flag and mask.
                if (pos == 2'd0)
                begin
                    is_long_frame_next = rx_byte[LONG_FLAG_BIT];
                    length_nibble_next = rx_byte[3:0];
                end
                phase_next = PHASE_HEADER;
                if (pos != 2'(HEADER_LAST_POS))
                begin
                    byte_position_next = {3'b000, pos} + 5'd1;
                end
                else
                begin
                    device_mask_next   = rx_byte;
                    byte_position_next = '0;
                    next_led_slot_next = '0;
                    if (!is_long_frame_reg)
                    begin
                        if (rx_byte == 8'h00)
                        begin
                            req.start = 1'b1;
                            req.kind  = REPLY_QUERY;
                        end
                        else
                        begin
                            phase_next = PHASE_DATA;
                        end
                    end
                end
            end
            else
            begin
                // Data phase: in an on command, the next masked LED ORs in this colour.
                if (device_mask_reg[ON_FLAG_BIT])
                begin
                    for (int i = 0; i < NUM_LEDS; i++)
                    begin
                        if (!found && (SLOT_W'(i) >= next_led_slot_reg) && device_mask_reg[i])
                        begin
                            led_pattern_next[i*BITS_PER_LED +: BITS_PER_LED] =
                                led_pattern_reg[i*BITS_PER_LED +: BITS_PER_LED] |
                                rx_byte[BITS_PER_LED-1:0];
                            next_led_slot_next = SLOT_W'(i + 1);
                            found              = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        next_led_slot_next = SLOT_W'(NUM_LEDS);
                    end
                end

                if (byte_position_reg < {1'b0, length_nibble_reg})
                begin
                    byte_position_next = byte_position_reg + 5'd1;
                end
                else
                begin
                    // Last data word: an off command clears the masked LEDs.
                    if (!device_mask_reg[ON_FLAG_BIT])
                    begin
                        for (int i = 0; i < NUM_LEDS; i++)
                        begin
                            if (device_mask_reg[i])
                            begin
                                led_pattern_next[i*BITS_PER_LED +: BITS_PER_LED] = '0;
                            end
                        end
                    end
                    phase_next         = PHASE_HEADER;
                    byte_position_next = '0;
                    next_led_slot_next = '0;
                    req.start          = 1'b1;
                    req.kind           = REPLY_OK;
                end
            end
        end
    end

    assign led_pattern = led_pattern_reg;

endmodule

`default_nettype wire

// ===== rtl/ulcfp_reply.sv =====
// Reply sender: streams one reply frame a word per cycle while out_ready is high.
`default_nettype none

module ulcfp_reply
    import ulcfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire reply_req_t req,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic            free,
    output logic [7:0]      tx_byte,
    output logic            tx_last
);

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    reply_kind_t kind_reg, kind_next;
    logic [3:0]  switches_reg, switches_next;

    // Sender registers; kind and switch copy are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        switches_reg <= switches_next;
    end

    // Current word and frame end.
    always_comb
    begin
        tx_byte = reply_byte(kind_reg, idx_reg, switches_reg);
        tx_last = (kind_reg == REPLY_QUERY) ? (idx_reg == QUERY_LAST_IDX)
                                            : (idx_reg == OK_LAST_IDX);
    end

    assign out_valid = busy_reg;
    assign free      = !busy_reg || (out_ready && tx_last);

    // Advance through the frame and load a new one when asked.
    always_comb
    begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        switches_next = switches_reg;
        if (busy_reg && out_ready)
        begin
            if (tx_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (req.start)
        begin
            busy_next     = 1'b1;
            idx_next      = '0;
            kind_next     = req.kind;
            switches_next = req.switches;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uart_led_command_frame_parser.sv =====
// Top level of the LED command frame parser.
//
// Input channel (in_valid/in_ready): one received serial word per transfer,
// rx_byte plus the current switch_levels, which are sampled on the final
// header word of a switch query.
// Output channel (out_valid/out_ready): reply frames, one word per transfer,
// tx_last high on the final word. led_drive carries the LED pattern as it
// stands after the command that caused the reply; it also drives the LEDs.
// A reply's first word is valid the cycle after the word that completes the
// command is accepted. A switch query reply is 6 words, an LED command reply
// 7 words.
// One input word per cycle while no reply is being sent. During a reply
// in_ready stays low; it rises again in the cycle the final reply word is
// taken: the single reply sender holds one frame at a time.
// When the receiver stalls, the current reply word holds and input waits.
// Reset clears the parser to the header phase and turns all LEDs off.
`default_nettype none

module uart_led_command_frame_parser
    import ulcfp_pkg::*;
#(
    parameter int NUM_LEDS     = DEFAULT_NUM_LEDS,
    parameter int BITS_PER_LED = DEFAULT_BITS_PER_LED
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic [3:0]                       switch_levels,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [7:0]                       tx_byte,
    output logic                                  tx_last,
    output logic      [NUM_LEDS*BITS_PER_LED-1:0] led_drive
);

    reply_req_t req;
    logic       free;

    // Parser with the frame state and LED pattern.
    ulcfp_parser #(
        .NUM_LEDS     (NUM_LEDS),
        .BITS_PER_LED (BITS_PER_LED)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_valid && in_ready),
        .rx_byte       (rx_byte),
        .switch_levels (switch_levels),
        .req           (req),
        .led_pattern   (led_drive)
    );

    // Reply frame sender.
    ulcfp_reply u_reply (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (free),
        .tx_byte   (tx_byte),
        .tx_last   (tx_last)
    );

    assign in_ready = free;

endmodule

`default_nettype wire
